// ===== hdl/stereo_multitap_early_reflections_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo early-reflection block
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_MULTITAP_EARLY_REFLECTIONS_TOP_MACROS_SVH
`define STEREO_MULTITAP_EARLY_REFLECTIONS_TOP_MACROS_SVH

// The consequent is checked in the cycle after the antecedent holds.
`define SMER_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent is checked in the same cycle as the antecedent.
`define SMER_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/smer_pkg.sv =====
// ----------------------------------------------------------------------------
// smer_pkg
// Types, tap tables and arithmetic widths of the stereo early-reflection block.
// ----------------------------------------------------------------------------
`default_nettype none

package smer_pkg;

   localparam int SAMPLE_RATE  = 48000;
   localparam int STORE_DEPTH  = 4096;
   localparam int SAMPLE_BITS  = 24;
   localparam int TAP_COUNT    = 6;
   localparam int TAP_SLOTS    = 6;

   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int FILL_BITS    = ADDR_BITS + 1;
   localparam int TAP_BITS     = $clog2(TAP_SLOTS);
   localparam int GAIN_BITS    = 14;
   localparam int COEFF_BITS   = 16;
   localparam int MIX_BITS     = COEFF_BITS + 1;
   localparam int TPROD_BITS   = SAMPLE_BITS + GAIN_BITS;
   localparam int ACC_BITS     = TPROD_BITS + TAP_BITS;
   localparam int S8_BITS      = ACC_BITS - 7;
   localparam int DIF_BITS     = S8_BITS + 1;
   localparam int FAC_BITS     = COEFF_BITS + 2;
   localparam int MUL_BITS     = FAC_BITS + DIF_BITS;
   localparam int OACC_BITS    = MUL_BITS + 1;

   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHELF_COEFF = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHELF_MIX   = CSR_INDEX_BITS'(1);

   localparam logic [COEFF_BITS-1:0] SHELF_COEFF_RESET = COEFF_BITS'(33635);
   localparam logic [COEFF_BITS-1:0] SHELF_MIX_RESET   = COEFF_BITS'(16384);
   localparam logic [MIX_BITS-1:0]   MIX_FULL          = MIX_BITS'(32768);

   localparam int unsigned LEFT_TENTHS  [TAP_SLOTS] = '{71, 133, 197, 271, 359, 433};
   localparam int unsigned RIGHT_TENTHS [TAP_SLOTS] = '{113, 179, 237, 311, 397, 449};

   localparam logic signed [GAIN_BITS-1:0] LEFT_GAIN [TAP_SLOTS] =
      '{14'sd5774, 14'sd4757, 14'sd3895, 14'sd3091, 14'sd2348, 14'sd1863};
   localparam logic signed [GAIN_BITS-1:0] RIGHT_GAIN [TAP_SLOTS] =
      '{14'sd5064, 14'sd4120, 14'sd3437, 14'sd2728, 14'sd2085, 14'sd1772};

   function automatic logic [ADDR_BITS-1:0] tap_delay(input int unsigned tenths);
      longint unsigned d;
      d = (longint'(tenths) * longint'(SAMPLE_RATE)) / 10000;
      if (d < 1) begin
         d = 1;
      end
      if (d > longint'(STORE_DEPTH - 1)) begin
         d = longint'(STORE_DEPTH - 1);
      end
      return ADDR_BITS'(d);
   endfunction

   localparam logic [ADDR_BITS-1:0] LEFT_DELAY [TAP_SLOTS] = '{
      tap_delay(LEFT_TENTHS[0]), tap_delay(LEFT_TENTHS[1]), tap_delay(LEFT_TENTHS[2]),
      tap_delay(LEFT_TENTHS[3]), tap_delay(LEFT_TENTHS[4]), tap_delay(LEFT_TENTHS[5])};
   localparam logic [ADDR_BITS-1:0] RIGHT_DELAY [TAP_SLOTS] = '{
      tap_delay(RIGHT_TENTHS[0]), tap_delay(RIGHT_TENTHS[1]), tap_delay(RIGHT_TENTHS[2]),
      tap_delay(RIGHT_TENTHS[3]), tap_delay(RIGHT_TENTHS[4]), tap_delay(RIGHT_TENTHS[5])};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } smer_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } smer_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TAPS,
      ST_DRAIN,
      ST_ROUND,
      ST_DIFF_LP,
      ST_MUL_LP,
      ST_UPD_LP,
      ST_DIFF_OUT,
      ST_MUL_OUT,
      ST_OUT
   } smer_state_type;

   typedef struct packed {
      logic acc_clear;
      logic mac_en;
      logic s8_en;
      logic diff_en;
      logic sel_mix;
      logic mul_en;
      logic lp_en;
   } smer_ctl_type;

   typedef struct packed {
      logic                          valid;
      logic signed [GAIN_BITS-1:0]   gain;
   } smer_tap_type;

endpackage

`default_nettype wire

// ===== hdl/smer_delay_ram.sv =====
// ----------------------------------------------------------------------------
// smer_delay_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smer_delay_ram #(
   parameter int DATA_BITS = 24,
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/smer_ctrl.sv =====
// ----------------------------------------------------------------------------
// smer_ctrl
// Sequencer: write pointer, fill count, tap read addresses and step enables.
// ----------------------------------------------------------------------------
`default_nettype none

module smer_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            rsp_free,
   output logic                                 rsp_load,
   output logic                                 wr_en,
   output logic [smer_pkg::ADDR_BITS-1:0]       wr_addr,
   output logic [smer_pkg::ADDR_BITS-1:0]       left_rd_addr,
   output logic [smer_pkg::ADDR_BITS-1:0]       right_rd_addr,
   output smer_pkg::smer_ctl_type               ctl,
   output smer_pkg::smer_tap_type               left_tap,
   output smer_pkg::smer_tap_type               right_tap
);

   import smer_pkg::*;

   smer_state_type          state_ff, state_in;
   logic [TAP_BITS-1:0]     tap_ff, tap_in;
   logic [ADDR_BITS-1:0]    wp_ff, wp_in;
   logic [FILL_BITS-1:0]    fill_ff, fill_in;
   logic                    mac_en_ff;
   smer_tap_type            left_tap_ff, left_tap_in;
   smer_tap_type            right_tap_ff, right_tap_in;
   logic [ADDR_BITS-1:0]    left_delay;
   logic [ADDR_BITS-1:0]    right_delay;
   logic                    accept;
   logic                    last_tap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tap_ff    <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
         mac_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tap_ff    <= tap_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         mac_en_ff <= (state_ff == ST_TAPS);
      end
   end

   always_ff @(posedge clock) begin
      left_tap_ff  <= left_tap_in;
      right_tap_ff <= right_tap_in;
   end

   assign left_delay    = LEFT_DELAY[tap_ff];
   assign right_delay   = RIGHT_DELAY[tap_ff];
   assign left_rd_addr  = wp_ff - left_delay;
   assign right_rd_addr = wp_ff - right_delay;

   // A tap reaching past the samples written since reset reads as zero.
   assign left_tap_in.valid  = (fill_ff >= {1'b0, left_delay});
   assign left_tap_in.gain   = LEFT_GAIN[tap_ff];
   assign right_tap_in.valid = (fill_ff >= {1'b0, right_delay});
   assign right_tap_in.gain  = RIGHT_GAIN[tap_ff];

   assign accept    = req_valid && !req_stall;
   assign last_tap  = (tap_ff == TAP_BITS'(TAP_COUNT - 1));
   assign req_stall = (state_ff != ST_IDLE);
   assign wr_en     = accept;
   assign wr_addr   = wp_ff;
   assign left_tap  = left_tap_ff;
   assign right_tap = right_tap_ff;

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      rsp_load      = 1'b0;
      ctl           = '0;
      ctl.mac_en    = mac_en_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.acc_clear = 1'b1;
               tap_in        = '0;
               state_in      = ST_TAPS;
            end
         end
         ST_TAPS: begin
            if (last_tap) begin
               wp_in    = wp_ff + 1'b1;
               fill_in  = (fill_ff == FILL_BITS'(STORE_DEPTH)) ? fill_ff : fill_ff + 1'b1;
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.s8_en = 1'b1;
            state_in  = ST_DIFF_LP;
         end
         ST_DIFF_LP: begin
            ctl.diff_en = 1'b1;
            state_in    = ST_MUL_LP;
         end
         ST_MUL_LP: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_UPD_LP;
         end
         ST_UPD_LP: begin
            ctl.lp_en = 1'b1;
            state_in  = ST_DIFF_OUT;
         end
         ST_DIFF_OUT: begin
            ctl.diff_en = 1'b1;
            state_in    = ST_MUL_OUT;
         end
         ST_MUL_OUT: begin
            ctl.sel_mix = 1'b1;
            ctl.mul_en  = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/smer_chan.sv =====
// ----------------------------------------------------------------------------
// smer_chan
// One channel's datapath: tap accumulation, one-pole lowpass and shelf mix.
// ----------------------------------------------------------------------------
`default_nettype none

module smer_chan (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire smer_pkg::smer_ctl_type                 ctl,
   input  wire smer_pkg::smer_tap_type                 tap,
   input  wire logic signed [smer_pkg::SAMPLE_BITS-1:0] rd_data,
   input  wire logic [smer_pkg::COEFF_BITS-1:0]        coeff,
   input  wire logic [smer_pkg::MIX_BITS-1:0]          mix,
   output logic signed [smer_pkg::SAMPLE_BITS-1:0]     sample_out
);

   import smer_pkg::*;

   localparam logic signed [ACC_BITS-1:0]  S8_ROUND  = ACC_BITS'(64);
   localparam logic signed [MUL_BITS-1:0]  LP_ROUND  = MUL_BITS'(32768);
   localparam logic signed [OACC_BITS-1:0] OUT_ROUND = OACC_BITS'(1 << 22);
   localparam logic signed [OACC_BITS-1:0] OUT_MAX   = OACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [OACC_BITS-1:0] OUT_MIN   = -OUT_MAX - OACC_BITS'(1);

   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [S8_BITS-1:0]    s8_ff;
   logic signed [S8_BITS-1:0]    lp_ff;
   logic signed [DIF_BITS-1:0]   dif_ff;
   logic signed [MUL_BITS-1:0]   mul_ff;

   logic signed [TPROD_BITS-1:0] tap_prod;
   logic signed [ACC_BITS-1:0]   acc_rnd;
   logic signed [DIF_BITS-1:0]   s8_ext;
   logic signed [DIF_BITS-1:0]   lp_ext;
   logic signed [FAC_BITS-1:0]   fac;
   logic signed [MUL_BITS-1:0]   mul_prod;
   logic signed [MUL_BITS-1:0]   lp_sum;
   logic signed [MUL_BITS-1:0]   lp_step;
   logic signed [OACC_BITS-1:0]  out_acc;
   logic signed [OACC_BITS-1:0]  out_q;
   logic signed [OACC_BITS-1:0]  out_sat;

   assign tap_prod = tap.gain * rd_data;
   assign acc_rnd  = acc_ff + S8_ROUND;
   assign s8_ext   = DIF_BITS'(s8_ff);
   assign lp_ext   = DIF_BITS'(lp_ff);
   assign fac      = ctl.sel_mix ? $signed({1'b0, mix}) : $signed({2'b00, coeff});
   assign mul_prod = fac * dif_ff;
   assign lp_sum   = mul_ff + LP_ROUND;
   assign lp_step  = lp_sum >>> 16;

   always_ff @(posedge clock) begin
      if (ctl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctl.mac_en && tap.valid) begin
         acc_ff <= acc_ff + ACC_BITS'(tap_prod);
      end
      if (ctl.s8_en) begin
         s8_ff <= S8_BITS'(acc_rnd >>> 7);
      end
      if (ctl.diff_en) begin
         dif_ff <= s8_ext - lp_ext;
      end
      if (ctl.mul_en) begin
         mul_ff <= mul_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= '0;
      end else if (ctl.lp_en) begin
         lp_ff <= lp_ff + S8_BITS'(lp_step);
      end
   end

   assign out_acc = (OACC_BITS'(s8_ff) <<< 15) - OACC_BITS'(mul_ff) + OUT_ROUND;
   assign out_q   = out_acc >>> 23;

   always_comb begin
      if (out_q > OUT_MAX) begin
         out_sat = OUT_MAX;
      end else if (out_q < OUT_MIN) begin
         out_sat = OUT_MIN;
      end else begin
         out_sat = out_q;
      end
   end

   assign sample_out = SAMPLE_BITS'(out_sat);

endmodule

`default_nettype wire

// ===== hdl/stereo_multitap_early_reflections_top.sv =====
// Each channel reads its six taps one per cycle through a single memory read
// port, then runs the drain, round, lowpass difference, multiply and update,
// and output difference and multiply states on one multiplier per channel; no
// new pair is taken until the last result is loaded. Reset clears the sequencer,
// write pointer, fill count, lowpass states, shelf settings and output valid;
// the delay memories are not swept, the fill count masks old entries.
// ----------------------------------------------------------------------------
// stereo_multitap_early_reflections_top
// Stereo early-reflection generator with six fixed taps per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_multitap_early_reflections_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire smer_pkg::smer_req_type                 req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output smer_pkg::smer_rsp_type                      rsp_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [smer_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [smer_pkg::COEFF_BITS-1:0]        csr_data
);

   import smer_pkg::*;

   logic [COEFF_BITS-1:0]         shelf_coeff_ff;
   logic [COEFF_BITS-1:0]         shelf_mix_ff;
   logic                          rsp_valid_ff;
   smer_rsp_type                  rsp_data_ff, rsp_data_in;
   logic [MIX_BITS-1:0]           mix_eff;
   logic                          rsp_free;
   logic                          rsp_load;
   logic                          wr_en;
   logic [ADDR_BITS-1:0]          wr_addr;
   logic [ADDR_BITS-1:0]          left_rd_addr;
   logic [ADDR_BITS-1:0]          right_rd_addr;
   logic [SAMPLE_BITS-1:0]        left_rd_data;
   logic [SAMPLE_BITS-1:0]        right_rd_data;
   smer_ctl_type                  ctl;
   smer_tap_type                  left_tap;
   smer_tap_type                  right_tap;
   logic signed [SAMPLE_BITS-1:0] left_result;
   logic signed [SAMPLE_BITS-1:0] right_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shelf_coeff_ff <= SHELF_COEFF_RESET;
         shelf_mix_ff   <= SHELF_MIX_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SHELF_COEFF) begin
            shelf_coeff_ff <= csr_data;
         end else if (csr_index == CSR_SHELF_MIX) begin
            shelf_mix_ff <= csr_data;
         end
      end
   end

   assign mix_eff = ({1'b0, shelf_mix_ff} > MIX_FULL) ? MIX_FULL : {1'b0, shelf_mix_ff};

   smer_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_free      (rsp_free),
      .rsp_load      (rsp_load),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .left_rd_addr  (left_rd_addr),
      .right_rd_addr (right_rd_addr),
      .ctl           (ctl),
      .left_tap      (left_tap),
      .right_tap     (right_tap)
   );

   smer_delay_ram #(
      .DATA_BITS (SAMPLE_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.left_sample),
      .rd_addr (left_rd_addr),
      .rd_data (left_rd_data)
   );

   smer_delay_ram #(
      .DATA_BITS (SAMPLE_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.right_sample),
      .rd_addr (right_rd_addr),
      .rd_data (right_rd_data)
   );

   smer_chan u_left_chan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .tap        (left_tap),
      .rd_data    ($signed(left_rd_data)),
      .coeff      (shelf_coeff_ff),
      .mix        (mix_eff),
      .sample_out (left_result)
   );

   smer_chan u_right_chan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .tap        (right_tap),
      .rd_data    ($signed(right_rd_data)),
      .coeff      (shelf_coeff_ff),
      .mix        (mix_eff),
      .sample_out (right_result)
   );

   assign rsp_free              = !rsp_valid_ff || !rsp_stall;
   assign rsp_data_in.left_out  = left_result;
   assign rsp_data_in.right_out = right_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/smer_checker.sv =====
// ----------------------------------------------------------------------------
// smer_checker
// Port-level checks of the early-reflection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_multitap_early_reflections_top_macros.svh"

module smer_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire smer_pkg::smer_rsp_type rsp_data
);

   import smer_pkg::*;

   // An accepted item keeps the block busy in the following cycle.
   `SMER_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy after accept")

   // A new result only comes out of a block that was busy working on an item.
   `SMER_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall), "result without work")

   // A stalled item stays in place.
   `SMER_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "item lost")

endmodule

bind stereo_multitap_early_reflections_top smer_checker u_smer_checker (.*);

`default_nettype wire

// ===== tb/stereo_multitap_early_reflections_top_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_multitap_early_reflections_top_tb
// Drives stereo sample pairs through the early-reflection block under random
// valid gaps and result stalls, across several shelf settings, and checks each
// output pair against a tap-sum, lowpass and shelf predictor kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_multitap_early_reflections_top_tb;
   import smer_pkg::*;

   localparam int TAPS       = 6;
   localparam int LINE_DEPTH = 4096;
   localparam int QUIET_MAX  = 2000;
   localparam int SHOWN_MAX  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_TOP = CSR_INDEX_BITS'(255);

   localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = 24'sh800000;

   localparam int unsigned L_TENTHS [TAPS] = '{71, 133, 197, 271, 359, 433};
   localparam int unsigned R_TENTHS [TAPS] = '{113, 179, 237, 311, 397, 449};
   localparam longint L_GAINS [TAPS] = '{5774, 4757, 3895, 3091, 2348, 1863};
   localparam longint R_GAINS [TAPS] = '{5064, 4120, 3437, 2728, 2085, 1772};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   smer_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   smer_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COEFF_BITS-1:0] csr_data = '0;

   logic signed [SAMPLE_BITS-1:0] left_line [LINE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_line [LINE_DEPTH];
   logic [11:0] line_ptr;
   longint left_lp;
   longint right_lp;
   logic [COEFF_BITS-1:0] coeff_q;
   logic [COEFF_BITS-1:0] mix_q;

   smer_req_type sample_queue [$];
   smer_rsp_type pending_outputs [$];
   int unsigned pairs_queued = 0;
   int unsigned pairs_taken = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_run = 0;
   logic req_took = 1'b0;
   logic steady = 1'b0;

   stereo_multitap_early_reflections_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // One channel of the reflection network, run after the new sample is stored.
   function automatic logic signed [SAMPLE_BITS-1:0] shelf_channel(input bit right_side,
         inout longint lp_state);
      longint tap_sum;
      longint s8;
      longint wet;
      longint coeff;
      longint mix;
      longint level;
      int unsigned span;
      logic [11:0] slot;
      tap_sum = 0;
      for (int t = 0; t < TAPS; t++) begin
         span = ((right_side ? R_TENTHS[t] : L_TENTHS[t]) * 48000) / 10000;
         if (span < 1) begin
            span = 1;
         end
         if (span > LINE_DEPTH - 1) begin
            span = LINE_DEPTH - 1;
         end
         slot = line_ptr - 12'(span);
         if (right_side) begin
            tap_sum += R_GAINS[t] * longint'(right_line[slot]);
         end else begin
            tap_sum += L_GAINS[t] * longint'(left_line[slot]);
         end
      end
      coeff = longint'(coeff_q);
      mix = (mix_q > 16'd32768) ? 64'sd32768 : longint'(mix_q);
      s8 = (tap_sum + 64'sd64) >>> 7;
      lp_state += (coeff * (s8 - lp_state) + 64'sd32768) >>> 16;
      wet = s8 * 64'sd32768 - mix * (s8 - lp_state);
      level = (wet + 64'sd4194304) >>> 23;
      if (level > 64'sd8388607) begin
         level = 64'sd8388607;
      end
      if (level < -64'sd8388608) begin
         level = -64'sd8388608;
      end
      return SAMPLE_BITS'(level);
   endfunction

   function automatic smer_rsp_type reflect_sample(input smer_req_type pair);
      smer_rsp_type result;
      left_line[line_ptr] = pair.left_sample;
      right_line[line_ptr] = pair.right_sample;
      result.left_out = shelf_channel(1'b0, left_lp);
      result.right_out = shelf_channel(1'b1, right_lp);
      line_ptr = line_ptr + 12'd1;
      return result;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 50) begin
         return SAMPLE_BITS'($urandom);
      end else if (kind < 65) begin
         return kind[0] ? PEAK_POS : PEAK_NEG;
      end else if (kind < 85) begin
         return SAMPLE_BITS'($signed($urandom_range(2047)) - 1024);
      end else begin
         return SAMPLE_BITS'($urandom) | PEAK_NEG;
      end
   endfunction

   task automatic queue_pair(input logic signed [SAMPLE_BITS-1:0] left,
         input logic signed [SAMPLE_BITS-1:0] right);
      smer_req_type pair;
      pair.left_sample = left;
      pair.right_sample = right;
      sample_queue.push_back(pair);
      pairs_queued++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
         input logic [COEFF_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (idx == CSR_SHELF_COEFF) begin
         coeff_q = value;
      end else if (idx == CSR_SHELF_MIX) begin
         mix_q = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_outputs();
      while (pairs_taken != pairs_queued || pending_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned made;
      int unsigned run_len;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 8) begin
            run_len = $urandom_range(80, 20);
            left = pick_sample();
            right = pick_sample();
            for (int i = 0; i < run_len; i++) begin
               queue_pair(left, right);
            end
            made += run_len;
         end else begin
            queue_pair(pick_sample(), pick_sample());
            made++;
         end
      end
      drain_outputs();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (!req_valid || req_took) begin
         if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
            req_valid <= 1'b1;
            req_data <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 25);
      end
   end

   always @(posedge clock) begin
      smer_rsp_type want;
      if (reset) begin
         req_took <= 1'b0;
         quiet_run = 0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            pending_outputs.push_back(reflect_sample(req_data));
            pairs_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX) begin
                  $display("unexpected output pair: left %0d right %0d",
                     rsp_data.left_out, rsp_data.right_out);
               end
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_data.left_out !== want.left_out ||
                     rsp_data.right_out !== want.right_out) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX) begin
                     $display("output mismatch: expected left %0d right %0d, got left %0d right %0d",
                        want.left_out, want.right_out, rsp_data.left_out, rsp_data.right_out);
                  end
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
               (csr_valid && csr_ready)) begin
            quiet_run = 0;
         end else begin
            quiet_run++;
         end
         if (quiet_run >= QUIET_MAX) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         left_line[i] = '0;
         right_line[i] = '0;
      end
      line_ptr = '0;
      left_lp = 0;
      right_lp = 0;
      coeff_q = SHELF_COEFF_RESET;
      mix_q = SHELF_MIX_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_pair(PEAK_POS, PEAK_POS);
      queue_pair(PEAK_NEG, PEAK_NEG);
      queue_pair(24'sd0, 24'sd0);
      queue_pair(-24'sd1, -24'sd1);
      queue_pair(24'sd1, -24'sd1);
      queue_pair(PEAK_POS, PEAK_NEG);
      queue_pair(PEAK_NEG, PEAK_POS);
      queue_pair(24'sh555555, 24'shAAAAAA);
      queue_pair(24'shAAAAAA, 24'sh555555);
      queue_pair(24'sh800001, 24'sh7FFFFE);
      for (int i = 0; i < 12; i++) begin
         queue_pair(PEAK_POS, PEAK_NEG);
      end
      random_phase(150);

      write_csr(CSR_SHELF_COEFF, 16'd0);
      write_csr(CSR_SHELF_MIX, 16'd32768);
      write_csr(CSR_UNUSED_LOW, 16'd65535);
      random_phase(120);

      steady = 1'b1;
      write_csr(CSR_SHELF_COEFF, 16'd65535);
      write_csr(CSR_SHELF_MIX, 16'd0);
      random_phase(120);
      steady = 1'b0;

      write_csr(CSR_SHELF_MIX, 16'd32768);
      write_csr(CSR_UNUSED_TOP, 16'd0);
      random_phase(120);

      write_csr(CSR_SHELF_COEFF, 16'd1);
      write_csr(CSR_SHELF_MIX, 16'd65535);
      random_phase(120);

      write_csr(CSR_SHELF_MIX, 16'd40000);
      write_csr(CSR_SHELF_COEFF, COEFF_BITS'($urandom));
      random_phase(120);

      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_SHELF_COEFF, COEFF_BITS'($urandom));
         write_csr(CSR_SHELF_MIX, COEFF_BITS'($urandom_range(36000)));
         random_phase(70);
      end

      drain_outputs();
      if (mismatches == 0 && pending_outputs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
